[design/sate_pkg.sv]
`timescale 1ns / 1ps

package sate_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int GUARD_BITS  = 16;
    localparam int LEAK_SHIFT  = 8;
    localparam int ACC_BITS    = SAMPLE_BITS + GUARD_BITS;
    localparam int WIDE_BITS   = ACC_BITS + 3;
    localparam int CALC_BITS   = ACC_BITS + 9;
    localparam int ONE_Q20     = 1 << 20;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_HI_GAIN      = 3'd0;
    localparam logic [2:0] CFG_TRIPLET_GAIN = 3'd1;
    localparam logic [2:0] CFG_AIR_GAIN     = 3'd2;
    localparam logic [2:0] CFG_INV_Q        = 3'd3;
    localparam logic [2:0] CFG_OUTPUT_GAIN  = 3'd4;
    localparam logic [2:0] CFG_WET_MIX      = 3'd5;

    // State memory layout, per channel.
    localparam int ENTRIES_PER_CH = 14;
    localparam int RAM_DEPTH      = 2 * ENTRIES_PER_CH;
    localparam int A_TRI          = 0;
    localparam int A_HIST         = 3;
    localparam int A_ODD          = 5;
    localparam int A_PREV         = 11;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8, S_T9,
        S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7,
        S_O0, S_O1, S_O2, S_O3,
        S_ML, S_MH,
        S_DONE
    } t_state;

    function automatic logic signed [ACC_BITS-1:0] sat_acc(
        input logic signed [CALC_BITS-1:0] v);
        logic [CALC_BITS-ACC_BITS:0] top;
        top = v[CALC_BITS-1:ACC_BITS-1];
        if (top == '0 || top == '1) begin
            return v[ACC_BITS-1:0];
        end else if (v[CALC_BITS-1]) begin
            return {1'b1, {(ACC_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_BITS-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [WIDE_BITS-1:0] sat_wide(
        input logic signed [CALC_BITS-1:0] v);
        logic [CALC_BITS-WIDE_BITS:0] top;
        top = v[CALC_BITS-1:WIDE_BITS-1];
        if (top == '0 || top == '1) begin
            return v[WIDE_BITS-1:0];
        end else if (v[CALC_BITS-1]) begin
            return {1'b1, {(WIDE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(WIDE_BITS-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
        input logic signed [CALC_BITS-1:0] v);
        logic [CALC_BITS-SAMPLE_BITS:0] top;
        top = v[CALC_BITS-1:SAMPLE_BITS-1];
        if (top == '0 || top == '1) begin
            return v[SAMPLE_BITS-1:0];
        end else if (v[CALC_BITS-1]) begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    endfunction

endpackage

[design/stereo_air_treble_enhancer_unit.sv]
`timescale 1ns / 1ps
// An accepted stereo pair is processed one channel at a time and then loaded into the
// output register; the block takes no new pair until it returns to idle, and a result
// waiting on the output holds it back.
// The channels run in turn through one state memory and one shared multiplier.
// Reset (synchronous, active low) clears the control state and all filter
// state; configuration registers return to their default values.

module stereo_air_treble_enhancer_unit
    import sate_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic signed [23:0] i_left_sample,
    input  logic signed [23:0] i_right_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [23:0] o_left_out,
    output logic signed [23:0] o_right_out
);

    localparam int AW = $clog2(RAM_DEPTH);
    localparam logic [23:0] ONE_MUL = 24'(ONE_Q20);

    // Configuration registers
    logic signed [22:0] r_hi_gain;
    logic signed [21:0] r_triplet_gain;
    logic signed [20:0] r_air_gain;
    logic [20:0] r_inv_filter_q, r_output_gain, r_wet_mix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_gain      <= '0;
            r_triplet_gain <= '0;
            r_air_gain     <= '0;
            r_inv_filter_q <= 21'd499322;
            r_output_gain  <= 21'(ONE_Q20);
            r_wet_mix      <= 21'(ONE_Q20);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HI_GAIN:      r_hi_gain      <= i_cfg_data[22:0];
                CFG_TRIPLET_GAIN: r_triplet_gain <= i_cfg_data[21:0];
                CFG_AIR_GAIN:     r_air_gain     <= i_cfg_data[20:0];
                CFG_INV_Q:        r_inv_filter_q <= i_cfg_data[20:0];
                CFG_OUTPUT_GAIN:  r_output_gain  <= i_cfg_data[20:0];
                CFG_WET_MIX:      r_wet_mix      <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Control and datapath registers
    t_state r_state, n_state, r_ret, n_ret;
    logic r_ch, n_ch, r_sec, n_sec;
    logic [1:0] r_phase, n_phase;
    logic r_flop, n_flop, r_flip1, n_flip1, r_flip2, n_flip2;
    logic signed [23:0] r_x_l, n_x_l, r_x_r, n_x_r, r_h, n_h;
    logic signed [ACC_BITS-1:0] r_a, n_a, r_b, n_b, r_c, n_c;
    logic signed [47:0] r_corr, n_corr, r_y, n_y, r_prod, n_prod;
    logic signed [WIDE_BITS-1:0] r_ma, n_ma;
    logic signed [23:0] r_mb, n_mb;
    logic signed [46:0] r_plo, n_plo;
    logic signed [23:0] r_res_l, n_res_l, r_res_r, n_res_r;
    logic r_out_valid, n_out_valid;
    logic signed [23:0] r_left_out, n_left_out, r_right_out, n_right_out;
    logic [RAM_DEPTH-1:0] r_vld;
    logic r_rvld;

    // Memory port
    logic [AW-1:0] rd_addr, wr_addr, base;
    logic we;
    logic [ACC_BITS-1:0] wr_data, ram_rdata;
    logic signed [ACC_BITS-1:0] rdv;

    sate_ram #(.WIDTH(ACC_BITS), .DEPTH(RAM_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(ram_rdata)
    );

    // Entries never written since reset read as zero.
    assign rdv  = r_rvld ? $signed(ram_rdata) : '0;
    assign base = r_ch ? AW'(ENTRIES_PER_CH) : '0;

    // Helper values
    logic signed [23:0] x;
    logic signed [24:0] dx;
    logic signed [ACC_BITS:0] f;
    logic signed [ACC_BITS-1:0] dry;
    logic signed [23:0] g_hi, g_tr, g_air, invq, ogc, wetc, dryw;
    logic [1:0] ph, ph_next, tri_i, tri_o, tri_t, sec_s;
    logic sec_even;
    logic signed [ACC_BITS:0] d_leak;
    logic signed [ACC_BITS-1:0] new_odd;
    logic signed [44:0] m_hi;
    logic signed [67:0] m_full, m_rnd;
    logic signed [CALC_BITS-1:0] y_sum, y_rnd;

    assign x    = r_ch ? r_x_r : r_x_l;
    assign dx   = 25'(r_h) - 25'(x);
    assign f    = $signed({dx, {GUARD_BITS{1'b0}}});
    assign dry  = $signed({x, {GUARD_BITS{1'b0}}});
    assign g_hi = 24'(r_hi_gain);
    assign g_tr = 24'(r_triplet_gain);
    assign g_air = 24'(r_air_gain);
    assign invq = $signed({3'b000, r_inv_filter_q});
    assign ogc  = (r_output_gain >= 21'(ONE_Q20)) ? ONE_MUL : $signed({3'b000, r_output_gain});
    assign wetc = (r_wet_mix >= 21'(ONE_Q20)) ? ONE_MUL : $signed({3'b000, r_wet_mix});
    assign dryw = ONE_MUL - wetc;

    // A phase of zero acts as phase one.
    assign ph      = (r_phase == 2'd0) ? 2'd1 : r_phase;
    assign ph_next = (ph == 2'd3) ? 2'd1 : ph + 2'd1;

    always_comb begin
        case (ph)
            2'd2:    begin tri_i = 2'd1; tri_o = 2'd0; tri_t = 2'd2; end
            2'd3:    begin tri_i = 2'd2; tri_o = 2'd1; tri_t = 2'd0; end
            default: begin tri_i = 2'd0; tri_o = 2'd2; tri_t = 2'd1; end
        endcase
    end

    // The first section is one of the alternating pair; the second always runs.
    assign sec_s    = r_sec ? 2'd2 : (r_flop ? 2'd0 : 2'd1);
    assign sec_even = r_sec ? r_flop : (r_flop ? r_flip1 : r_flip2);

    assign new_odd = sat_acc(CALC_BITS'(r_prod));
    assign d_leak  = (ACC_BITS+1)'(r_a) - (ACC_BITS+1)'(r_b);

    // Shared multiplier: low and high partial products on successive cycles.
    assign m_hi   = $signed(r_ma[WIDE_BITS-1:22]) * r_mb;
    assign m_full = (68'(m_hi) <<< 22) + 68'(r_plo);
    assign m_rnd  = (m_full + 68'sd524288) >>> 20;

    assign y_sum = CALC_BITS'(r_corr) + CALC_BITS'(r_prod);
    assign y_rnd = (y_sum + CALC_BITS'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;   n_ch = r_ch;     n_sec = r_sec;
        n_phase = r_phase;  n_flop = r_flop; n_flip1 = r_flip1; n_flip2 = r_flip2;
        n_x_l = r_x_l;      n_x_r = r_x_r;   n_h = r_h;
        n_a = r_a;          n_b = r_b;       n_c = r_c;
        n_corr = r_corr;    n_y = r_y;       n_prod = r_prod;
        n_ma = r_ma;        n_mb = r_mb;     n_plo = r_plo;
        n_res_l = r_res_l;  n_res_r = r_res_r;
        n_out_valid = r_out_valid && !i_out_ready;
        n_left_out = r_left_out;  n_right_out = r_right_out;
        rd_addr = '0;  we = 1'b0;  wr_addr = '0;  wr_data = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x_l = i_left_sample;
                    n_x_r = i_right_sample;
                    n_ch = 1'b0;
                    n_state = S_T0;
                end
            end
            S_T0: begin
                rd_addr = base + AW'(A_HIST);
                n_state = S_T1;
            end
            S_T1: begin
                n_h = rdv[23:0];
                rd_addr = base + AW'(A_HIST + 1);
                n_state = S_T2;
            end
            S_T2: begin
                we = 1'b1;
                wr_addr = base + AW'(A_HIST);
                wr_data = rdv;
                rd_addr = base + AW'(A_TRI) + AW'(tri_i);
                n_state = S_T3;
            end
            S_T3: begin
                we = 1'b1;
                wr_addr = base + AW'(A_HIST + 1);
                wr_data = ACC_BITS'(x);
                n_a = sat_acc(CALC_BITS'(rdv) + CALC_BITS'(f));
                rd_addr = base + AW'(A_TRI) + AW'(tri_o);
                n_state = S_T4;
            end
            S_T4: begin
                n_b = sat_acc(CALC_BITS'(rdv) - CALC_BITS'(f));
                rd_addr = base + AW'(A_TRI) + AW'(tri_t);
                n_state = S_T5;
            end
            S_T5: begin
                n_c = rdv;
                n_ma = WIDE_BITS'(r_a);  n_mb = g_tr;  n_ret = S_T6;  n_state = S_ML;
            end
            S_T6: begin
                n_corr = r_prod;
                n_ma = WIDE_BITS'(r_a);  n_mb = invq;  n_ret = S_T7;  n_state = S_ML;
            end
            S_T7: begin
                we = 1'b1;
                wr_addr = base + AW'(A_TRI) + AW'(tri_i);
                wr_data = new_odd;
                n_ma = WIDE_BITS'(r_b);  n_mb = invq;  n_ret = S_T8;  n_state = S_ML;
            end
            S_T8: begin
                we = 1'b1;
                wr_addr = base + AW'(A_TRI) + AW'(tri_o);
                wr_data = new_odd;
                n_ma = WIDE_BITS'(r_c);  n_mb = invq;  n_ret = S_T9;  n_state = S_ML;
            end
            S_T9: begin
                we = 1'b1;
                wr_addr = base + AW'(A_TRI) + AW'(tri_t);
                wr_data = new_odd;
                n_sec = 1'b0;
                n_state = S_A0;
            end
            S_A0: begin
                rd_addr = base + AW'(A_PREV) + AW'(sec_s);
                n_state = S_A1;
            end
            S_A1: begin
                n_h = rdv[23:0];
                we = 1'b1;
                wr_addr = base + AW'(A_PREV) + AW'(sec_s);
                wr_data = ACC_BITS'(x);
                rd_addr = base + AW'(A_ODD) + AW'({sec_s, 1'b0});
                n_state = S_A2;
            end
            S_A2: begin
                n_a = rdv;
                rd_addr = base + AW'(A_ODD + 1) + AW'({sec_s, 1'b0});
                n_state = S_A3;
            end
            S_A3: begin
                if (sec_even) begin
                    n_b = sat_acc(CALC_BITS'(rdv) + CALC_BITS'(f));
                    n_a = sat_acc(CALC_BITS'(r_a) - CALC_BITS'(f));
                end else begin
                    n_a = sat_acc(CALC_BITS'(r_a) + CALC_BITS'(f));
                    n_b = sat_acc(CALC_BITS'(rdv) - CALC_BITS'(f));
                end
                n_state = S_A4;
            end
            S_A4: begin
                n_ma = sec_even ? WIDE_BITS'(r_b) : WIDE_BITS'(r_a);
                n_mb = r_sec ? g_hi : g_air;
                n_ret = S_A5;
                n_state = S_ML;
            end
            S_A5: begin
                n_corr = r_corr + r_prod;
                n_ma = WIDE_BITS'(r_a) - WIDE_BITS'(d_leak >>> LEAK_SHIFT);
                n_mb = invq;  n_ret = S_A6;  n_state = S_ML;
            end
            S_A6: begin
                // The even update leaks toward the odd value just computed.
                we = 1'b1;
                wr_addr = base + AW'(A_ODD) + AW'({sec_s, 1'b0});
                wr_data = new_odd;
                n_ma = WIDE_BITS'(r_b) - WIDE_BITS'(
                    ((ACC_BITS+1)'(r_b) - (ACC_BITS+1)'(new_odd)) >>> LEAK_SHIFT);
                n_mb = invq;  n_ret = S_A7;  n_state = S_ML;
            end
            S_A7: begin
                we = 1'b1;
                wr_addr = base + AW'(A_ODD + 1) + AW'({sec_s, 1'b0});
                wr_data = new_odd;
                if (!r_sec) begin
                    n_sec = 1'b1;
                    n_state = S_A0;
                end else begin
                    n_state = S_O0;
                end
            end
            S_O0: begin
                // A gain of one multiplies by exactly one.
                n_ma = sat_wide(CALC_BITS'(dry) + CALC_BITS'(r_corr));
                n_mb = ogc;  n_ret = S_O1;  n_state = S_ML;
            end
            S_O1: begin
                n_y = r_prod;
                n_ma = WIDE_BITS'(dry);  n_mb = dryw;  n_ret = S_O2;  n_state = S_ML;
            end
            S_O2: begin
                n_corr = r_prod;
                n_ma = WIDE_BITS'(r_y);  n_mb = wetc;  n_ret = S_O3;  n_state = S_ML;
            end
            S_O3: begin
                if (!r_ch) begin
                    n_res_l = sat_smp(y_rnd);
                    n_ch = 1'b1;
                    n_state = S_T0;
                end else begin
                    n_res_r = sat_smp(y_rnd);
                    n_state = S_DONE;
                end
            end
            S_ML: begin
                n_plo = $signed({1'b0, r_ma[21:0]}) * r_mb;
                n_state = S_MH;
            end
            S_MH: begin
                n_prod = m_rnd[47:0];
                n_state = r_ret;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_left_out = r_res_l;
                    n_right_out = r_res_r;
                    if (r_flop) begin
                        n_flip1 = !r_flip1;
                    end else begin
                        n_flip2 = !r_flip2;
                    end
                    n_flop = !r_flop;
                    n_phase = ph_next;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_ch <= 1'b0;
            r_sec <= 1'b0;
            r_phase <= 2'd1;
            r_flop <= 1'b0;
            r_flip1 <= 1'b0;
            r_flip2 <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_ch <= n_ch;
            r_sec <= n_sec;
            r_phase <= n_phase;
            r_flop <= n_flop;
            r_flip1 <= n_flip1;
            r_flip2 <= n_flip2;
            r_out_valid <= n_out_valid;
            if (we) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_rvld <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_l <= n_x_l;   r_x_r <= n_x_r;   r_h <= n_h;
        r_a <= n_a;       r_b <= n_b;       r_c <= n_c;
        r_corr <= n_corr; r_y <= n_y;       r_prod <= n_prod;
        r_ma <= n_ma;     r_mb <= n_mb;     r_plo <= n_plo;
        r_res_l <= n_res_l;   r_res_r <= n_res_r;
        r_left_out <= n_left_out;   r_right_out <= n_right_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

[design/sate_ram.sv]
`timescale 1ns / 1ps

module sate_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 28
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/sate_checker.sv]
`timescale 1ns / 1ps

module sate_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_left_out,
    input logic [23:0] o_right_out
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_left_out) && $stable(o_right_out))
        else $error("stalled output transaction changed");

    // The block works on one pair at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a pair is in progress");

    // No result follows an accepted input in the very next cycle.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind stereo_air_treble_enhancer_unit sate_assert u_sate_assert (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_left_out (o_left_out),
    .o_right_out(o_right_out)
);
